>>> design/rch_pkg.sv
// Shared types, constants and register codes for the column-height raycaster.
package rch_pkg;

    // Default map geometry
    localparam int MAP_COLS_DEF    = 16;
    localparam int MAP_ROWS_DEF    = 16;
    localparam int TILE_PIXELS_DEF = 64;

    // Field widths
    localparam int COL_W   = 10;
    localparam int POS_W   = 18;
    localparam int ANG_W   = 12;
    localparam int CELL_W  = 4;
    localparam int SH_W    = 12;
    localparam int MAXD_W  = 12;
    localparam int FOV_W   = 11;
    localparam int RSTEP_W = 16;
    localparam int MSTEP_W = 8;
    localparam int OUT_W   = 16;
    localparam int ACC_W   = 20;     // ray angle accumulator, Q12.8
    localparam int DIST_W  = 20;     // march distance, Q12.8
    localparam int TRIG_W  = 16;     // signed Q1.14
    localparam int POSX_W  = 38;     // ray point, Q.22 signed
    localparam int FRAC_SH = 22;
    localparam int CORR_W  = DIST_W + TRIG_W + 1;
    localparam int DIV_NW  = SH_W + 1 + FRAC_SH;   // 2*rows << 22
    localparam int DIV_DW  = CORR_W - 1;

    // Config port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SCR_ROWS      = 3'd0,
        REG_MAX_DISTANCE  = 3'd1,
        REG_HALF_FOV      = 3'd2,
        REG_RAY_STEP      = 3'd3,
        REG_MARCH_STEP    = 3'd4
    } t_reg_idx;

    localparam logic [SH_W-1:0]    RST_SCR_ROWS      = 12'd480;
    localparam logic [MAXD_W-1:0]  RST_MAX_DISTANCE  = 12'd640;
    localparam logic [FOV_W-1:0]   RST_HALF_FOV      = 11'd341;
    localparam logic [RSTEP_W-1:0] RST_RAY_STEP      = 16'd273;
    localparam logic [MSTEP_W-1:0] RST_MARCH_STEP    = 8'd26;

    // Binary angle quarter turn
    localparam logic [ANG_W-1:0] QUARTER_TURN = 12'd1024;

    // Quarter-wave sine polynomial coefficients
    localparam logic [14:0] SIN_C1 = 15'd1160;
    localparam logic [14:0] SIN_C2 = 15'd10512;
    localparam logic [14:0] SIN_C3 = 15'd25736;

    localparam logic [OUT_W-1:0] HEIGHT_SAT = 16'hFFFF;

    typedef enum logic [1:0] {
        HIT_WALL  = 2'd0,
        HIT_LEFT  = 2'd1,
        HIT_LIMIT = 2'd2
    } t_hit;

    localparam logic ACT_RAY   = 1'b0;
    localparam logic ACT_WRITE = 1'b1;

    typedef struct packed {
        logic              action;
        logic [COL_W-1:0]  column;
        logic [POS_W-1:0]  player_x;
        logic [POS_W-1:0]  player_y;
        logic [ANG_W-1:0]  player_angle;
        logic [CELL_W-1:0] cell_x;
        logic [CELL_W-1:0] cell_y;
        logic              cell_wall;
    } t_in_word;

    typedef struct packed {
        logic [COL_W-1:0]        out_column;
        logic signed [OUT_W-1:0] wall_top;
        logic [OUT_W-1:0]        wall_height;
        logic [1:0]              hit_kind;
    } t_out_word;

endpackage

>>> design/raycast_column_height.sv
// Top level of the column-height raycaster: control sequencer, tile map and datapath.
//
// One word at a time. A map-write word updates the map as it is taken and
// gives no result. A ray word computes its angle, evaluates three sines on a
// shared polynomial unit, then marches: each march step passes through
// advance, tile index, map read and check, bounded by the single read port
// of the tile map; a ray makes at most ceil(max_distance*256 / march_step)
// march steps, and its height then comes from the serial divider or saturates.
// A finished result sits in an output register, so the next word is taken
// while it waits. After reset the map is cleared by a pass over all
// MAP_COLS*MAP_ROWS cells, during which no word is accepted; configuration
// writes are taken at any time and should come only while no ray is in flight.
module raycast_column_height #(
    parameter int MAP_COLS    = rch_pkg::MAP_COLS_DEF,
    parameter int MAP_ROWS    = rch_pkg::MAP_ROWS_DEF,
    parameter int TILE_PIXELS = rch_pkg::TILE_PIXELS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input word channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  rch_pkg::t_in_word                  i_in_word,
    // result word channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output rch_pkg::t_out_word                 o_out_word,
    // config write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [rch_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [rch_pkg::CFG_DATA_W-1:0]     i_cfg_data
);
    localparam int DEPTH = MAP_COLS * MAP_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = $clog2(MAP_COLS);
    localparam int YW    = $clog2(MAP_ROWS);
    localparam int XSPAN = MAP_COLS * TILE_PIXELS;
    localparam int YSPAN = MAP_ROWS * TILE_PIXELS;
    localparam int SPAN  = (XSPAN > YSPAN) ? XSPAN : YSPAN;
    localparam int PIXW  = $clog2(SPAN);
    // reciprocal of the tile size, exact for every pixel below SPAN
    localparam int RK    = PIXW + 9;
    localparam int MW    = RK + 1;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << RK) + TILE_PIXELS - 1) / TILE_PIXELS);

    localparam int PW  = rch_pkg::POSX_W;
    localparam int DW  = rch_pkg::DIST_W;
    localparam int TW  = rch_pkg::TRIG_W;
    localparam int AGW = rch_pkg::ANG_W;

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_CLEAR     = 14'b00000000000010,
        ST_ANGLE     = 14'b00000000000100,
        ST_TRIG_GO   = 14'b00000000001000,
        ST_TRIG_WAIT = 14'b00000000010000,
        ST_SETUP     = 14'b00000000100000,
        ST_STEP      = 14'b00000001000000,
        ST_TILE      = 14'b00000010000000,
        ST_ADDR      = 14'b00000100000000,
        ST_CHECK     = 14'b00001000000000,
        ST_CORR      = 14'b00010000000000,
        ST_DIV_GO    = 14'b00100000000000,
        ST_DIV_WAIT  = 14'b01000000000000,
        ST_FINISH    = 14'b10000000000000
    } t_state;

    t_state r_state, n_state;

    // configuration
    logic [rch_pkg::SH_W-1:0]    r_scr_rows;
    logic [rch_pkg::MAXD_W-1:0]  r_max_distance;
    logic [rch_pkg::FOV_W-1:0]   r_half_fov;
    logic [rch_pkg::RSTEP_W-1:0] r_ray_step;
    logic [rch_pkg::MSTEP_W-1:0] r_march_step;

    // ray context
    logic [rch_pkg::COL_W-1:0] r_column, n_column;
    logic [rch_pkg::POS_W-1:0] r_px, n_px;
    logic [rch_pkg::POS_W-1:0] r_py, n_py;
    logic [AGW-1:0]            r_pa, n_pa;
    logic [AGW-1:0]            r_ang, n_ang;
    logic [1:0]                r_tsel, n_tsel;
    logic signed [TW-1:0]      r_cos, n_cos;
    logic signed [TW-1:0]      r_sin, n_sin;
    logic signed [TW-1:0]      r_cosf, n_cosf;
    logic signed [PW-1:0]      r_dx, n_dx;
    logic signed [PW-1:0]      r_dy, n_dy;
    logic signed [PW-1:0]      r_xs, n_xs;
    logic signed [PW-1:0]      r_ys, n_ys;
    logic [DW-1:0]             r_d, n_d;
    logic [XW-1:0]             r_qx, n_qx;
    logic [YW-1:0]             r_qy, n_qy;
    rch_pkg::t_hit             r_kind, n_kind;
    logic signed [rch_pkg::CORR_W-1:0] r_corr, n_corr;
    logic [rch_pkg::OUT_W-1:0] r_h, n_h;
    logic [AW-1:0]             r_clr, n_clr;

    // output register
    logic               r_out_valid, n_out_valid;
    rch_pkg::t_out_word r_out, n_out;

    // map ram
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic          ram_wdata;
    logic [AW-1:0] ram_raddr;
    logic          ram_rdata;

    // trig and divider
    logic                 trig_start;
    logic [AGW-1:0]       trig_angle;
    logic                 trig_done;
    logic signed [TW-1:0] trig_value;
    logic                 div_start;
    logic                 div_done;
    logic [rch_pkg::OUT_W-1:0]  div_quot;
    logic [rch_pkg::DIV_NW-1:0] div_num;
    logic [rch_pkg::DIV_DW-1:0] div_den;

    // datapath helpers
    logic                  in_take;
    logic                  cell_ok;
    logic [rch_pkg::ACC_W-1:0] acc;
    logic [25:0]           col_mul;
    logic [rch_pkg::MSTEP_W-1:0] step;
    logic [DW-1:0]         limit;
    logic signed [TW+rch_pkg::MSTEP_W:0] dx_mul, dy_mul;
    logic [PW-3-rch_pkg::FRAC_SH:0] pix_x, pix_y;
    logic [PIXW+MW-1:0]    rx_mul, ry_mul;
    logic                  out_room;

    rch_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_map (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rch_sine u_sine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (trig_start),
        .i_angle (trig_angle),
        .o_done  (trig_done),
        .o_value (trig_value)
    );

    rch_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    assign in_take  = i_in_valid && (r_state == ST_IDLE);
    assign cell_ok  = (int'(i_in_word.cell_x) < MAP_COLS) && (int'(i_in_word.cell_y) < MAP_ROWS);
    assign step     = (r_march_step == '0) ? rch_pkg::MSTEP_W'(1) : r_march_step;
    assign limit    = {r_max_distance, 8'b0};
    assign out_room = !r_out_valid || !i_out_stall;

    // map port: clearing pass, then map-write words; read data is used only while marching
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = 1'b0;
        end else begin
            ram_we    = in_take && (i_in_word.action == rch_pkg::ACT_WRITE) && cell_ok;
            ram_waddr = AW'(int'(i_in_word.cell_y) * MAP_COLS + int'(i_in_word.cell_x));
            ram_wdata = i_in_word.cell_wall;
        end
        ram_raddr = AW'(int'(r_qy) * MAP_COLS + int'(r_qx));
    end

    // sine selection: cos(ray), sin(ray), cos(ray - player) for fish-eye
    always_comb begin
        case (r_tsel)
            2'd0:    trig_angle = r_ang + rch_pkg::QUARTER_TURN;
            2'd1:    trig_angle = r_ang;
            default: trig_angle = r_ang - r_pa + rch_pkg::QUARTER_TURN;
        endcase
        trig_start = (r_state == ST_TRIG_GO);
        div_start  = (r_state == ST_DIV_GO);
        div_num    = {r_scr_rows, 1'b0, {rch_pkg::FRAC_SH{1'b0}}};
        div_den    = r_corr[rch_pkg::DIV_DW-1:0];
    end

    always_comb begin
        col_mul = r_column * r_ray_step;
        acc     = {r_pa, 8'b0} - {1'b0, r_half_fov, 8'b0} + col_mul[rch_pkg::ACC_W-1:0];
        dx_mul  = r_cos * $signed({1'b0, step});
        dy_mul  = r_sin * $signed({1'b0, step});
        pix_x   = r_xs[PW-3:rch_pkg::FRAC_SH];
        pix_y   = r_ys[PW-3:rch_pkg::FRAC_SH];
        rx_mul  = pix_x[PIXW-1:0] * RECIP;
        ry_mul  = pix_y[PIXW-1:0] * RECIP;
    end

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_column    = r_column;
        n_px        = r_px;
        n_py        = r_py;
        n_pa        = r_pa;
        n_ang       = r_ang;
        n_tsel      = r_tsel;
        n_cos       = r_cos;
        n_sin       = r_sin;
        n_cosf      = r_cosf;
        n_dx        = r_dx;
        n_dy        = r_dy;
        n_xs        = r_xs;
        n_ys        = r_ys;
        n_d         = r_d;
        n_qx        = r_qx;
        n_qy        = r_qy;
        n_kind      = r_kind;
        n_corr      = r_corr;
        n_h         = r_h;
        n_clr       = r_clr;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            ST_CLEAR: begin
                n_clr = r_clr + 1'b1;
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_take && i_in_word.action == rch_pkg::ACT_RAY) begin
                    n_column = i_in_word.column;
                    n_px     = i_in_word.player_x;
                    n_py     = i_in_word.player_y;
                    n_pa     = i_in_word.player_angle;
                    n_state  = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                n_ang   = acc[rch_pkg::ACC_W-1:8];
                n_tsel  = 2'd0;
                n_state = ST_TRIG_GO;
            end
            ST_TRIG_GO: begin
                n_state = ST_TRIG_WAIT;
            end
            ST_TRIG_WAIT: begin
                if (trig_done) begin
                    case (r_tsel)
                        2'd0:    n_cos  = trig_value;
                        2'd1:    n_sin  = trig_value;
                        default: n_cosf = trig_value;
                    endcase
                    if (r_tsel == 2'd2) begin
                        n_state = ST_SETUP;
                    end else begin
                        n_tsel  = r_tsel + 2'd1;
                        n_state = ST_TRIG_GO;
                    end
                end
            end
            ST_SETUP: begin
                n_dx = PW'(dx_mul);
                n_dy = PW'(dy_mul);
                n_xs = $signed({{(PW-rch_pkg::POS_W-14){1'b0}}, r_px, 14'b0});
                n_ys = $signed({{(PW-rch_pkg::POS_W-14){1'b0}}, r_py, 14'b0});
                n_d  = '0;
                if (limit == '0) begin
                    n_kind  = rch_pkg::HIT_LIMIT;
                    n_state = ST_CORR;
                end else begin
                    n_state = ST_STEP;
                end
            end
            ST_STEP: begin
                n_d     = r_d + DW'(step);
                n_xs    = r_xs + r_dx;
                n_ys    = r_ys + r_dy;
                n_state = ST_TILE;
            end
            ST_TILE: begin
                // negative or beyond the map edge: ray left the map
                if (r_xs[PW-1] || r_ys[PW-1] || int'(pix_x) >= XSPAN || int'(pix_y) >= YSPAN) begin
                    n_kind  = rch_pkg::HIT_LEFT;
                    n_d     = limit;
                    n_state = ST_CORR;
                end else begin
                    n_qx    = rx_mul[RK +: XW];
                    n_qy    = ry_mul[RK +: YW];
                    n_state = ST_ADDR;
                end
            end
            ST_ADDR: begin
                n_state = ST_CHECK;
            end
            ST_CHECK: begin
                if (ram_rdata) begin
                    n_kind  = rch_pkg::HIT_WALL;
                    n_state = ST_CORR;
                end else if (r_d < limit) begin
                    n_state = ST_STEP;
                end else begin
                    n_kind  = rch_pkg::HIT_LIMIT;
                    n_d     = limit;
                    n_state = ST_CORR;
                end
            end
            ST_CORR: begin
                n_corr  = $signed({1'b0, r_d}) * r_cosf;
                n_state = ST_DIV_GO;
            end
            ST_DIV_GO: begin
                if (r_corr <= 0) begin
                    n_h     = rch_pkg::HEIGHT_SAT;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_DIV_WAIT;
                end
            end
            ST_DIV_WAIT: begin
                if (div_done) begin
                    n_h     = div_quot;
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (out_room) begin
                    n_out.out_column  = r_column;
                    n_out.wall_height = r_h;
                    n_out.wall_top    = $signed({5'b0, r_scr_rows[rch_pkg::SH_W-1:1]})
                                      - $signed({1'b0, r_h[rch_pkg::OUT_W-1:1]});
                    n_out.hit_kind    = r_kind;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= ST_CLEAR;
            r_clr           <= '0;
            r_out_valid     <= 1'b0;
            r_tsel          <= 2'd0;
            r_scr_rows      <= rch_pkg::RST_SCR_ROWS;
            r_max_distance  <= rch_pkg::RST_MAX_DISTANCE;
            r_half_fov      <= rch_pkg::RST_HALF_FOV;
            r_ray_step      <= rch_pkg::RST_RAY_STEP;
            r_march_step    <= rch_pkg::RST_MARCH_STEP;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
            r_tsel      <= n_tsel;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rch_pkg::REG_SCR_ROWS:      r_scr_rows      <= i_cfg_data[rch_pkg::SH_W-1:0];
                    rch_pkg::REG_MAX_DISTANCE:  r_max_distance  <= i_cfg_data[rch_pkg::MAXD_W-1:0];
                    rch_pkg::REG_HALF_FOV:      r_half_fov      <= i_cfg_data[rch_pkg::FOV_W-1:0];
                    rch_pkg::REG_RAY_STEP:      r_ray_step      <= i_cfg_data;
                    rch_pkg::REG_MARCH_STEP:    r_march_step    <= i_cfg_data[rch_pkg::MSTEP_W-1:0];
                    default: ;
                endcase
            end
        end
        r_column <= n_column;
        r_px     <= n_px;
        r_py     <= n_py;
        r_pa     <= n_pa;
        r_ang    <= n_ang;
        r_cos    <= n_cos;
        r_sin    <= n_sin;
        r_cosf   <= n_cosf;
        r_dx     <= n_dx;
        r_dy     <= n_dy;
        r_xs     <= n_xs;
        r_ys     <= n_ys;
        r_d      <= n_d;
        r_qx     <= n_qx;
        r_qy     <= n_qy;
        r_kind   <= n_kind;
        r_corr   <= n_corr;
        r_h      <= n_h;
        r_out    <= n_out;
    end
endmodule

>>> design/rch_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rch_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> design/rch_sine.sv
// Sequential binary-angle sine: quarter-wave polynomial on one shared multiplier.
module rch_sine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [rch_pkg::ANG_W-1:0]         i_angle,
    output logic                              o_done,
    output logic signed [rch_pkg::TRIG_W-1:0] o_value
);
    logic        r_busy, n_busy;
    logic        r_done, n_done;
    logic [1:0]  r_step, n_step;
    logic [14:0] r_z, n_z;
    logic [14:0] r_z2, n_z2;
    logic [14:0] r_t, n_t;
    logic        r_neg, n_neg;
    logic signed [rch_pkg::TRIG_W-1:0] r_val, n_val;

    logic [10:0] rr;
    logic [14:0] ma, mb;
    logic [29:0] prod;
    logic [14:0] res;

    always_comb begin
        rr = i_angle[10] ? (11'd1024 - {1'b0, i_angle[9:0]}) : {1'b0, i_angle[9:0]};
        case (r_step)
            2'd0:    begin ma = r_z;  mb = r_z;                 end
            2'd1:    begin ma = r_z2; mb = rch_pkg::SIN_C1;       end
            2'd2:    begin ma = r_z2; mb = rch_pkg::SIN_C2 - r_t; end
            default: begin ma = r_z;  mb = rch_pkg::SIN_C3 - r_t; end
        endcase
        prod = ma * mb;
        res  = prod[28:14];

        n_busy = r_busy;
        n_done = 1'b0;
        n_step = r_step;
        n_z    = r_z;
        n_z2   = r_z2;
        n_t    = r_t;
        n_neg  = r_neg;
        n_val  = r_val;
        if (i_start) begin
            n_busy = 1'b1;
            n_step = 2'd0;
            n_z    = {rr, 4'b0};
            n_neg  = i_angle[11];
        end else if (r_busy) begin
            n_step = r_step + 2'd1;
            case (r_step)
                2'd0:    n_z2 = res;
                2'd1:    n_t  = res;
                2'd2:    n_t  = res;
                default: begin
                    n_val  = r_neg ? -$signed({1'b0, res}) : $signed({1'b0, res});
                    n_busy = 1'b0;
                    n_done = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= 2'd0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_step <= n_step;
        end
        r_z   <= n_z;
        r_z2  <= n_z2;
        r_t   <= n_t;
        r_neg <= n_neg;
        r_val <= n_val;
    end

    assign o_done  = r_done;
    assign o_value = r_val;
endmodule

>>> design/rch_div.sv
// Restoring divider, one quotient bit per cycle, result saturated to 16 bits.
module rch_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [rch_pkg::DIV_NW-1:0]   i_num,
    input  logic [rch_pkg::DIV_DW-1:0]   i_den,
    output logic                         o_done,
    output logic [rch_pkg::OUT_W-1:0]    o_quot
);
    localparam int NW = rch_pkg::DIV_NW;
    localparam int DW = rch_pkg::DIV_DW;
    localparam int CW = $clog2(NW + 1);

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_num, n_num;
    logic [NW-1:0] r_q, n_q;
    logic [DW-1:0] r_rem, n_rem;
    logic [DW-1:0] r_den, n_den;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_sub;
    logic          ge;

    always_comb begin
        rem_sh  = {r_rem, r_num[NW-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        ge      = rem_sh >= {1'b0, r_den};

        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_num  = r_num;
        n_q    = r_q;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_num  = i_num;
            n_den  = i_den;
            n_rem  = '0;
            n_q    = '0;
        end else if (r_busy) begin
            n_rem = ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
            n_num = {r_num[NW-2:0], 1'b0};
            n_q   = {r_q[NW-2:0], ge};
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CW'(NW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_num <= n_num;
        r_q   <= n_q;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done = r_done;
    assign o_quot = (|r_q[NW-1:rch_pkg::OUT_W]) ? rch_pkg::HEIGHT_SAT : r_q[rch_pkg::OUT_W-1:0];
endmodule

>>> tb/raycast_column_height_chk.sv
// Checker for the column-height raycaster: watches the channels, predicts results and compares.
`timescale 1ns / 100ps
module raycast_column_height_chk
    import rch_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  t_in_word   i_in_word,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  t_out_word  i_out_word,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int         o_errors,
    output int         o_pending
);
    logic        wall_map [256];
    logic [11:0] scr_h, max_d;
    logic [10:0] hfov;
    logic [15:0] rstep;
    logic [7:0]  mstep;
    t_out_word   heights_due [$];
    int          err_cnt;

    assign o_errors  = err_cnt;
    assign o_pending = heights_due.size();

    function automatic longint quarter_sin(longint r);
        longint z, z2, t;
        z  = r * 16;
        z2 = (z * z) >>> 14;
        t  = (z2 * 1160) >>> 14;
        t  = (z2 * (10512 - t)) >>> 14;
        return (z * (25736 - t)) >>> 14;
    endfunction

    function automatic longint sin_q14(int a);
        int r, q;
        longint v;
        a = a & 4095;
        r = a & 1023;
        q = a >> 10;
        v = (q & 1) ? quarter_sin(1024 - r) : quarter_sin(r);
        return (q >= 2) ? -v : v;
    endfunction

    // Cast one ray against the current map and settings.
    function automatic t_out_word cast_column(t_in_word w);
        t_out_word o;
        int acc, ang, kind;
        longint cx, sy, d, lim, st, xs, ys, tx, ty, corr, h;
        acc = ((int'(w.player_angle) << 8) - (int'(hfov) << 8)
               + int'(w.column) * int'(rstep)) & 20'hFFFFF;
        ang = acc >> 8;
        cx = sin_q14(ang + 1024);
        sy = sin_q14(ang);
        lim = longint'(max_d) << 8;
        st = (mstep != 0) ? mstep : 1;
        d = 0;
        kind = HIT_LIMIT;
        while (d < lim) begin
            d += st;
            xs = longint'(w.player_x) * 16384 + cx * d;
            ys = longint'(w.player_y) * 16384 + sy * d;
            if (xs < 0 || ys < 0) begin
                kind = HIT_LEFT;
                break;
            end
            tx = (xs >>> 22) / 64;
            ty = (ys >>> 22) / 64;
            if (tx >= 16 || ty >= 16) begin
                kind = HIT_LEFT;
                break;
            end
            if (wall_map[ty*16 + tx]) begin
                kind = HIT_WALL;
                break;
            end
        end
        if (kind != HIT_WALL) d = lim;
        corr = d * sin_q14(((ang - int'(w.player_angle)) & 4095) + 1024);
        if (corr <= 0) h = 65535;
        else begin
            h = ((longint'(scr_h) * 2) << 22) / corr;
            if (h > 65535) h = 65535;
        end
        o.out_column  = w.column;
        o.wall_top    = 16'(int'(scr_h / 2) - int'(h / 2));
        o.wall_height = 16'(h);
        o.hit_kind    = kind[1:0];
        return o;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_out_word e;
        if (!i_rst_n) begin
            foreach (wall_map[k]) wall_map[k] = 1'b0;
            scr_h = RST_SCR_ROWS; max_d = RST_MAX_DISTANCE;
            hfov = RST_HALF_FOV; rstep = RST_RAY_STEP; mstep = RST_MARCH_STEP;
            heights_due.delete();
            err_cnt = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (heights_due.size() == 0)
                    report_mismatch("unexpected word, column", i_out_word.out_column, -1);
                else begin
                    e = heights_due.pop_front();
                    if (i_out_word.out_column != e.out_column)
                        report_mismatch("out_column", i_out_word.out_column, e.out_column);
                    if (i_out_word.wall_top != e.wall_top)
                        report_mismatch("wall_top", i_out_word.wall_top, e.wall_top);
                    if (i_out_word.wall_height != e.wall_height)
                        report_mismatch("wall_height", i_out_word.wall_height,
                                        e.wall_height);
                    if (i_out_word.hit_kind != e.hit_kind)
                        report_mismatch("hit_kind", i_out_word.hit_kind, e.hit_kind);
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    REG_SCR_ROWS:      scr_h = i_cfg_data[11:0];
                    REG_MAX_DISTANCE:  max_d = i_cfg_data[11:0];
                    REG_HALF_FOV:      hfov  = i_cfg_data[10:0];
                    REG_RAY_STEP:      rstep = i_cfg_data;
                    REG_MARCH_STEP:    mstep = i_cfg_data[7:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_word.action == ACT_WRITE)
                    wall_map[{i_in_word.cell_y, i_in_word.cell_x}] = i_in_word.cell_wall;
                else
                    heights_due.push_back(cast_column(i_in_word));
            end
        end
    end
endmodule

>>> tb/raycast_column_height_tb.sv
// Testbench top for the column-height raycaster: stimulus, config phases and verdict.
`timescale 1ns / 100ps
module raycast_column_height_tb;
    import rch_pkg::*;

    localparam int IN_W = $bits(t_in_word);

    logic      i_clk, i_rst_n;
    logic      in_valid, in_stall, out_valid, out_stall;
    t_in_word  in_word;
    t_out_word out_word;
    logic      cfg_valid, cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int        errors, pending;
    longint    cycles;
    bit        calm;        // stretch with no idling on either side
    bit        hold_rx;     // long receiver hold-off
    int        hold_left;

    raycast_column_height i_dut (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_word(in_word),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_word(out_word),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    raycast_column_height_chk i_chk (
        .i_clk, .i_rst_n,
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_word(in_word),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_word(out_word),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Receiver: random stall, or a long hold-off (longer than two rays) counted here.
    always @(posedge i_clk) begin
        if (hold_rx && hold_left == 0) hold_left <= 60000;
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else
            out_stall <= !calm && ($urandom_range(99) < 13);
    end

    // Watchdog; ends the run and reports errors if it runs too long.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 40_000_000) begin
            $display("raycast_column_height_tb: errors");
            $finish;
        end
    end

    // Valid stays up after the accepting edge only until the next word or idle.
    task automatic send_word(t_in_word w);
        while (!calm && $urandom_range(99) < 13) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic write_reg(t_reg_idx idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= 16'(val);
        do @(posedge i_clk); while (!cfg_ready);
    endtask

    // Drain all results, then give the last (resultless) word time to settle.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    task automatic set_all(int sh, int md, int hf, int rs, int ms);
        drain();
        write_reg(REG_SCR_ROWS, sh);
        write_reg(REG_MAX_DISTANCE, md);
        write_reg(REG_HALF_FOV, hf);
        write_reg(REG_RAY_STEP, rs);
        write_reg(REG_MARCH_STEP, ms);
        cfg_valid <= 1'b0;
    endtask

    function automatic t_in_word ray_word(int col, int px, int py, int pa);
        t_in_word w;
        w = t_in_word'(IN_W'({$urandom, $urandom, $urandom}));
        w.action = ACT_RAY;
        w.column = 10'(col); w.player_x = 18'(px);
        w.player_y = 18'(py); w.player_angle = 12'(pa);
        return w;
    endfunction

    function automatic t_in_word map_word(int x, int y, int wall);
        t_in_word w;
        w = t_in_word'(IN_W'({$urandom, $urandom, $urandom}));
        w.action = ACT_WRITE;
        w.cell_x = 4'(x); w.cell_y = 4'(y); w.cell_wall = 1'(wall);
        return w;
    endfunction

    function automatic t_in_word rand_word();
        // Mostly rays from inside the map, some map edits and far positions.
        if ($urandom_range(99) < 30)
            return map_word($urandom_range(15), $urandom_range(15), $urandom_range(1));
        if ($urandom_range(99) < 15)
            return ray_word($urandom_range(1023), $urandom_range(262143),
                            $urandom_range(262143), $urandom_range(4095));
        return ray_word($urandom_range(1023), $urandom_range(1023 * 256),
                        $urandom_range(1023 * 256), $urandom_range(4095));
    endfunction

    initial begin
        i_rst_n = 1'b0; in_valid = 1'b0; in_word = '0; out_stall = 1'b0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        calm = 1'b0; hold_rx = 1'b0; hold_left = 0; cycles = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: open map, then walls, position and angle extremes.
        send_word(ray_word(0, 0, 0, 0));
        send_word(ray_word(1023, 262143, 262143, 4095));
        send_word(ray_word(320, 512 * 256, 512 * 256, 1024));
        send_word(map_word(8, 8, 1));
        send_word(map_word(0, 0, 1));
        send_word(map_word(15, 15, 1));
        send_word(ray_word(320, 300 * 256, 530 * 256, 0));
        send_word(ray_word(320, 530 * 256, 300 * 256, 1024));
        send_word(ray_word(0, 10 * 256, 10 * 256, 2048));
        send_word(ray_word(5, 1000 * 256, 1000 * 256, 512));
        send_word(map_word(8, 8, 0));
        send_word(ray_word(320, 300 * 256, 530 * 256, 0));
        // Zero march step, zero max distance, extremes of every register.
        set_all(4095, 4095, 2047, 65535, 0);
        send_word(ray_word(1023, 512 * 256, 512 * 256, 3000));
        send_word(ray_word(0, 100 * 256, 100 * 256, 0));
        set_all(1, 0, 0, 0, 255);
        send_word(ray_word(7, 512 * 256, 512 * 256, 100));
        set_all(1, 1, 0, 0, 255);
        send_word(ray_word(7, 512 * 256, 512 * 256, 100));
        send_word(ray_word(700, 1000, 1000, 2048));
        set_all(480, 640, 341, 273, 26);

        // Pressure: receiver holds off while rays keep coming.
        hold_rx = 1'b1;
        repeat (6) send_word(rand_word());
        hold_rx = 1'b0;

        // Random phases under several settings; the second one runs calm.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                1: set_all(240, 300, 200, 400, 128);
                2: set_all($urandom_range(1, 4095), $urandom_range(1, 1024),
                           $urandom_range(2047), $urandom_range(65535),
                           $urandom_range(16, 255));
                3: set_all(4095, 1, 2047, 65535, 1);
                default: ;
            endcase
            calm = (ph == 1);
            repeat (25) send_word(rand_word());
        end
        calm = 1'b0;
        drain();
        if (errors == 0)
            $display("raycast_column_height_tb: clean");
        else
            $display("raycast_column_height_tb: errors");
        $finish;
    end
endmodule

>>> files.f
design/rch_pkg.sv
design/rch_ram.sv
design/rch_sine.sv
design/rch_div.sv
design/raycast_column_height.sv
tb/raycast_column_height_chk.sv
tb/raycast_column_height_tb.sv
